### src/tgarle_pkg.sv
// Shared types and constants for the Targa RLE row decoder.
// No dependencies; every other file of the block imports this package.
package tgarle_pkg;

  // Field widths of the stream byte, the result and the configuration.
  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int RUN_W      = 8;
  localparam int BPP_W      = 3;
  localparam int ROW_W      = 18;
  localparam int CFG_DATA_W = ROW_W;
  localparam int CFG_IDX_W  = 1;

  // Width that holds the product of a packet pixel count (up to 128) and bytes per pixel (up to 4).
  localparam int NEED_W = 10;

  // Packet header fields.
  localparam logic [BYTE_W-1:0] HDR_REPEAT_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] HDR_COUNT_MASK  = 8'h7f;

  // Reset values of the configuration registers.
  localparam logic [BPP_W-1:0] BPP_RESET       = 3'd3;
  localparam logic [ROW_W-1:0] ROW_BYTES_RESET = 18'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'b1;

  // Result status codes.
  localparam logic STATUS_PIXEL   = 1'b0;
  localparam logic STATUS_OVERRUN = 1'b1;

  // One configuration write.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One result item.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic [RUN_W-1:0]   run_length;
    logic               row_end;
    logic               status;
  } out_item_t;

  // Result handed from the decode core to the output buffer.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

### src/tgarle_if.sv
// Valid/ready channel interfaces for the compressed stream and the results.
// Depends on tgarle_pkg for field widths.
interface tgarle_in_if;
  import tgarle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface tgarle_out_if;
  import tgarle_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;
  logic [RUN_W-1:0]   run_length;
  logic               row_end;
  logic               status;

  modport source (output valid, output pixel_word, output run_length, output row_end,
                  output status, input ready);
  modport sink   (input valid, input pixel_word, input run_length, input row_end,
                  input status, output ready);
endinterface

### src/tga_rle_row_decoder.sv
// Top level of the Targa RLE row decoder.
// Depends on tgarle_pkg, the channel interfaces, tgarle_core and tgarle_obuf.

// The decoder takes one compressed byte per clock while the result buffer has room,
// and turns Targa RLE packets into pixel results with a run length: one result per
// repeat packet, one per pixel of a raw packet, and an overrun status when a packet
// would pass the end of the row, after which bytes are dropped until one arrives
// with restart set. The result of a byte appears on the result channel at the
// earliest in the next cycle. A two-entry result buffer holds finished results, and
// the stream channel drops ready only while both entries are full. Configuration may
// be written only while no transfer is in flight.
module tga_rle_row_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data,
  tgarle_in_if.sink                         stream,
  tgarle_out_if.source                      result
);
  import tgarle_pkg::*;

  cfg_wr_t cfg;
  res_t    res;
  logic    space;
  logic    accept;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // A byte transfers whenever the result buffer has room.
  assign stream.ready = space;
  assign accept       = stream.valid && space;

  tgarle_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (stream.in_byte),
    .restart (stream.restart),
    .res     (res)
  );

  tgarle_obuf u_obuf (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .space  (space),
    .result (result)
  );

endmodule

### src/tgarle_core.sv
// Decode core: configuration registers, packet and row state, one byte per transfer.
// Depends on tgarle_pkg.
module tgarle_core (
  input  logic                          clk,
  input  logic                          rst,
  input  tgarle_pkg::cfg_wr_t           cfg,
  input  logic                          accept,
  input  logic [tgarle_pkg::BYTE_W-1:0] in_byte,
  input  logic                          restart,
  output tgarle_pkg::res_t              res
);
  import tgarle_pkg::*;

  // Configuration registers.
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [ROW_W-1:0] row_bytes;

  // Decoder state.
  logic [ROW_W-1:0]   bytes_left;
  logic [RUN_W-1:0]   pix_left;
  logic               is_repeat;
  logic [1:0]         byte_in_pixel;
  logic [PIXEL_W-1:0] pixel_asm;
  logic               halted;

  logic [ROW_W-1:0]   bytes_left_next;
  logic [RUN_W-1:0]   pix_left_next;
  logic               is_repeat_next;
  logic [1:0]         byte_in_pixel_next;
  logic [PIXEL_W-1:0] pixel_asm_next;
  logic               halted_next;
  res_t               res_next;

  // State as seen after a restart has cleared it.
  logic [ROW_W-1:0]   bytes_left_c;
  logic [RUN_W-1:0]   pix_left_c;
  logic               is_repeat_c;
  logic [1:0]         byte_in_pixel_c;
  logic [PIXEL_W-1:0] pixel_asm_c;
  logic               halted_c;

  logic [BPP_W-1:0]   eff_bpp;
  logic [RUN_W-1:0]   count;
  logic [NEED_W-1:0]  need;
  logic [ROW_W-1:0]   row_left;
  logic [PIXEL_W-1:0] asm_merged;
  logic [2:0]         bytes_seen;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      row_bytes       <= ROW_BYTES_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data[BPP_W-1:0];
        REG_ROW_BYTES:       row_bytes       <= cfg.data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Bytes per pixel is clamped to the range one to four.
  always_comb begin
    if (bytes_per_pixel == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (bytes_per_pixel > 3'd4) begin
      eff_bpp = 3'd4;
    end else begin
      eff_bpp = bytes_per_pixel;
    end
  end

  // A restart clears all partial state before the byte is looked at.
  assign bytes_left_c    = restart ? '0 : bytes_left;
  assign pix_left_c      = restart ? '0 : pix_left;
  assign is_repeat_c     = restart ? 1'b0 : is_repeat;
  assign byte_in_pixel_c = restart ? 2'd0 : byte_in_pixel;
  assign pixel_asm_c     = restart ? '0 : pixel_asm;
  assign halted_c        = restart ? 1'b0 : halted;

  // Header arithmetic: pixel count, decoded bytes it needs, and the row budget.
  assign count    = (in_byte & HDR_COUNT_MASK) + 8'd1;
  assign need     = NEED_W'(count) * NEED_W'(eff_bpp);
  assign row_left = (bytes_left_c == '0) ? row_bytes : bytes_left_c;

  // Pixel assembly: the new byte lands above those already collected.
  assign asm_merged = pixel_asm_c | (PIXEL_W'(in_byte) << {byte_in_pixel_c, 3'b000});
  assign bytes_seen = {1'b0, byte_in_pixel_c} + 3'd1;

  // Next state and result for one transfer.
  always_comb begin
    bytes_left_next    = bytes_left_c;
    pix_left_next      = pix_left_c;
    is_repeat_next     = is_repeat_c;
    byte_in_pixel_next = byte_in_pixel_c;
    pixel_asm_next     = pixel_asm_c;
    halted_next        = halted_c;
    res_next           = '0;
    if (!halted_c) begin
      if (pix_left_c == '0) begin
        bytes_left_next = row_left;
        if (ROW_W'(need) > row_left) begin
          // Packet overruns the row: report it and halt.
          halted_next                = 1'b1;
          res_next.valid             = 1'b1;
          res_next.item.status       = STATUS_OVERRUN;
        end else begin
          bytes_left_next    = row_left - ROW_W'(need);
          pix_left_next      = count;
          is_repeat_next     = (in_byte & HDR_REPEAT_MASK) != '0;
          byte_in_pixel_next = 2'd0;
          pixel_asm_next     = '0;
        end
      end else if (bytes_seen >= eff_bpp) begin
        // Pixel complete: a repeat packet ends here, a raw one counts down.
        res_next.valid           = 1'b1;
        res_next.item.pixel_word = asm_merged;
        res_next.item.status     = STATUS_PIXEL;
        if (is_repeat_c) begin
          res_next.item.run_length = pix_left_c;
          pix_left_next            = '0;
        end else begin
          res_next.item.run_length = 8'd1;
          pix_left_next            = pix_left_c - 8'd1;
        end
        res_next.item.row_end = (pix_left_next == '0) && (bytes_left_c == '0);
        byte_in_pixel_next    = 2'd0;
        pixel_asm_next        = '0;
      end else begin
        byte_in_pixel_next = bytes_seen[1:0];
        pixel_asm_next     = asm_merged;
      end
    end
    if (!accept) begin
      res_next.valid = 1'b0;
    end
  end

  // State registers advance only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      pix_left      <= '0;
      is_repeat     <= 1'b0;
      byte_in_pixel <= 2'd0;
      pixel_asm     <= '0;
      halted        <= 1'b0;
    end else if (accept) begin
      bytes_left    <= bytes_left_next;
      pix_left      <= pix_left_next;
      is_repeat     <= is_repeat_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_asm     <= pixel_asm_next;
      halted        <= halted_next;
    end
  end

  // The result leaves combinationally; the output buffer registers it.
  assign res = res_next;

endmodule

### src/tgarle_obuf.sv
// Two-entry result buffer that decouples the decoder from result backpressure.
// Depends on tgarle_pkg and the result channel interface.
module tgarle_obuf (
  input  logic               clk,
  input  logic               rst,
  input  tgarle_pkg::res_t   res,
  output logic               space,
  tgarle_out_if.source       result
);
  import tgarle_pkg::*;

  out_item_t  q0;
  out_item_t  q1;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign push  = res.valid;
  assign pop   = (cnt != 2'd0) && result.ready;
  assign space = (cnt != 2'd2);

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Entry storage; the head entry is always q0.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd2) begin
        q0 <= q1;
        q1 <= res.item;
      end else begin
        q0 <= res.item;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        q0 <= res.item;
      end else begin
        q1 <= res.item;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign result.valid      = (cnt != 2'd0);
  assign result.pixel_word = q0.pixel_word;
  assign result.run_length = q0.run_length;
  assign result.row_end    = q0.row_end;
  assign result.status     = q0.status;

endmodule

### src/tgarle_checker.sv
// Port-level checks for the Targa RLE row decoder, bound to the top level.
// Depends on tgarle_pkg.
module tgarle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_valid,
  input logic                           s_ready,
  input logic                           r_valid,
  input logic                           r_ready,
  input logic [tgarle_pkg::PIXEL_W-1:0] r_pixel_word,
  input logic [tgarle_pkg::RUN_W-1:0]   r_run_length,
  input logic                           r_row_end,
  input logic                           r_status
);
  import tgarle_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_pixel_word) && $stable(r_run_length)
      && $stable(r_row_end) && $stable(r_status))
    else $error("stalled result changed");

  // An overrun result carries no pixel, no run and no row end.
  a_overrun: assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_status == STATUS_OVERRUN) |->
      (r_pixel_word == '0) && (r_run_length == '0) && !r_row_end)
    else $error("overrun result with nonzero fields");

  // A pixel result repeats one to 128 times.
  a_run: assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_status == STATUS_PIXEL) |-> (r_run_length != '0) && (r_run_length <= 8'd128))
    else $error("pixel result run length out of range");

  // A result only shows up after a byte has been transferred.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    r_valid && !$past(r_valid) |-> $past(s_valid && s_ready))
    else $error("result without a preceding byte transfer");

endmodule

bind tga_rle_row_decoder tgarle_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_valid      (stream.valid),
  .s_ready      (stream.ready),
  .r_valid      (result.valid),
  .r_ready      (result.ready),
  .r_pixel_word (result.pixel_word),
  .r_run_length (result.run_length),
  .r_row_end    (result.row_end),
  .r_status     (result.status)
);
